@@ src/tgrm_pkg.sv @@
`timescale 1ns / 1ps
package tgrm_pkg;
  localparam int MAX_COLUMNS_DEF = 32;
  localparam int MAX_ROWS_DEF = 32;
  localparam int TILE_PIXELS_DEF = 32;
  localparam int CODE_W = 8;
  localparam int PX_W = 11;
  localparam int EPOCH_W = 8;
  localparam int RAM_DATA_W_DEF = 8;
  localparam int RAM_ADDR_W_DEF = 10;

  localparam logic [1:0] KIND_RECT = 2'd0;
  localparam logic [1:0] KIND_VLINE = 2'd1;
  localparam logic [1:0] KIND_HLINE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_VCODE = 2'd2;
  localparam logic [1:0] CFG_HCODE = 2'd3;
endpackage

@@ src/tgrm_ram.sv @@
`timescale 1ns / 1ps
module tgrm_ram #(
  parameter int DATA_W = tgrm_pkg::RAM_DATA_W_DEF,
  parameter int ADDR_W = tgrm_pkg::RAM_ADDR_W_DEF
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

@@ src/tile_grid_rectangle_merger_unit.sv @@
`timescale 1ns / 1ps
// load request: no result. fetch with lines pending: result in the next cycle.
// other fetch: scans cells down each column, grows a found cell down, then right,
// marks each covered cell and emits it; the memory read latency sets the pace.
// results are strobed for one cycle; the receiver cannot stall.
// reset (and every 255th load) starts a clearing pass over all MAX_COLUMNS*MAX_ROWS
// entries of the covered map, during which busy is high.
module tile_grid_rectangle_merger_unit #(
  parameter int MAX_COLUMNS = tgrm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = tgrm_pkg::MAX_ROWS_DEF,
  parameter int TILE_PIXELS = tgrm_pkg::TILE_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [4:0] cell_column,
  input  logic [4:0] cell_row,
  input  logic [7:0] tile_code,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       result_strobe,
  output logic [1:0] shape_kind,
  output logic [7:0] shape_code,
  output logic [10:0] left_px,
  output logic [10:0] top_px,
  output logic [10:0] right_px,
  output logic [10:0] bottom_px
);
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MAXD = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int DW = $clog2(MAXD + 1);
  localparam int CW = tgrm_pkg::CODE_W;
  localparam int EW = tgrm_pkg::EPOCH_W;

  typedef enum logic [3:0] {
    IDLE, CLEAR, SCAN, SCHK, DRD, DCHK, RRD, RCHK, CINIT, COV, EMIT
  } state_t;

  state_t state;
  logic [5:0] board_columns, board_rows;
  logic [CW-1:0] vcode, hcode;
  logic [DW-1:0] cols_eff, rows_eff;
  logic [DW-1:0] c, r, sc, sr, bottom, right, k;
  logic [CW-1:0] code;
  logic [DW-1:0] rect_left, rect_top, rect_right, rect_bottom, line_cursor;
  logic [CW-1:0] rect_code;
  logic lines_pending, line_is_vertical;
  logic [EW-1:0] epoch;
  logic [AW:0] clr;

  logic [6:0] rd_col, rd_row, wr_col, wr_row;
  logic [AW-1:0] rd_addr, code_wr_addr, tag_wr_addr;
  logic code_we, tag_we;
  logic [EW-1:0] tag_wr_data, rd_tag;
  logic [CW-1:0] rd_code;
  logic accept;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] col, input logic [6:0] row);
    logic [AW:0] t;
    t = (AW+1)'(col) * (AW+1)'(MAX_ROWS) + (AW+1)'(row);
    return t[AW-1:0];
  endfunction

  function automatic logic [10:0] px(input logic [DW-1:0] b);
    logic [17:0] p;
    p = 18'(b) * 18'(TILE_PIXELS);
    return p[10:0];
  endfunction

  assign busy = (state != IDLE);
  assign accept = start && !busy;
  assign cols_eff = (7'(board_columns) > 7'(MAX_COLUMNS)) ? DW'(MAX_COLUMNS)
                                                          : DW'(board_columns);
  assign rows_eff = (7'(board_rows) > 7'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(board_rows);

  always_comb begin
    rd_col = '0;
    rd_row = '0;
    case (state)
      SCAN: begin
        rd_col = 7'(c);
        rd_row = 7'(r);
      end
      DRD: begin
        rd_col = 7'(sc);
        rd_row = 7'(bottom) + 7'd1;
      end
      RRD: begin
        rd_col = 7'(right) + 7'd1;
        rd_row = 7'(k);
      end
      default: ;
    endcase
  end

  assign rd_addr = cell_addr(rd_col, rd_row);
  assign wr_col = 7'(cell_column);
  assign wr_row = 7'(cell_row);
  assign code_wr_addr = cell_addr(wr_col, wr_row);
  assign code_we = accept && !operation && (wr_col < 7'(MAX_COLUMNS))
                   && (wr_row < 7'(MAX_ROWS));
  assign tag_we = (state == COV) || (state == CLEAR);
  assign tag_wr_addr = (state == CLEAR) ? clr[AW-1:0] : cell_addr(7'(c), 7'(k));
  assign tag_wr_data = (state == CLEAR) ? '0 : epoch;

  tgrm_ram #(.DATA_W(CW), .ADDR_W(AW)) u_codes (
    .clk(clk), .wr_en(code_we), .wr_addr(code_wr_addr), .wr_data(tile_code),
    .rd_addr(rd_addr), .rd_data(rd_code)
  );

  tgrm_ram #(.DATA_W(EW), .ADDR_W(AW)) u_cover (
    .clk(clk), .wr_en(tag_we), .wr_addr(tag_wr_addr), .wr_data(tag_wr_data),
    .rd_addr(rd_addr), .rd_data(rd_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      board_columns <= 6'd32;
      board_rows <= 6'd32;
      vcode <= '0;
      hcode <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tgrm_pkg::CFG_COLUMNS: board_columns <= cfg_data[5:0];
        tgrm_pkg::CFG_ROWS: board_rows <= cfg_data[5:0];
        tgrm_pkg::CFG_VCODE: vcode <= cfg_data;
        tgrm_pkg::CFG_HCODE: hcode <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      clr <= '0;
      epoch <= '0;
      lines_pending <= 1'b0;
      line_is_vertical <= 1'b0;
      result_strobe <= 1'b0;
      rect_left <= '0;
      rect_top <= '0;
      rect_right <= '0;
      rect_bottom <= '0;
      rect_code <= '0;
      line_cursor <= '0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (accept && !operation) begin
            lines_pending <= 1'b0;
            if (epoch == {EW{1'b1}}) begin
              state <= CLEAR;
              clr <= '0;
            end else begin
              epoch <= epoch + 1'b1;
            end
          end else if (accept) begin
            if (lines_pending) begin
              result_strobe <= 1'b1;
              shape_code <= rect_code;
              if (line_is_vertical) begin
                shape_kind <= tgrm_pkg::KIND_VLINE;
                left_px <= px(line_cursor);
                right_px <= px(line_cursor);
                top_px <= px(rect_top);
                bottom_px <= px(rect_bottom);
                if (line_cursor >= rect_right) lines_pending <= 1'b0;
                else line_cursor <= line_cursor + 1'b1;
              end else begin
                shape_kind <= tgrm_pkg::KIND_HLINE;
                left_px <= px(rect_left);
                right_px <= px(rect_right);
                top_px <= px(line_cursor);
                bottom_px <= px(line_cursor);
                if (line_cursor >= rect_bottom) lines_pending <= 1'b0;
                else line_cursor <= line_cursor + 1'b1;
              end
            end else if (cols_eff == '0 || rows_eff == '0) begin
              result_strobe <= 1'b1;
              shape_kind <= tgrm_pkg::KIND_DONE;
              shape_code <= '0;
              left_px <= '0;
              top_px <= '0;
              right_px <= '0;
              bottom_px <= '0;
            end else begin
              c <= '0;
              r <= '0;
              state <= SCAN;
            end
          end
        end
        CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(CELLS - 1)) begin
            epoch <= EW'(1);
            state <= IDLE;
          end
        end
        SCAN: state <= SCHK;
        SCHK: begin
          if (rd_code != '0 && rd_tag != epoch) begin
            sc <= c;
            sr <= r;
            code <= rd_code;
            bottom <= r;
            state <= DRD;
          end else if (r + 1'b1 < rows_eff) begin
            r <= r + 1'b1;
            state <= SCAN;
          end else if (c + 1'b1 < cols_eff) begin
            r <= '0;
            c <= c + 1'b1;
            state <= SCAN;
          end else begin
            result_strobe <= 1'b1;
            shape_kind <= tgrm_pkg::KIND_DONE;
            shape_code <= '0;
            left_px <= '0;
            top_px <= '0;
            right_px <= '0;
            bottom_px <= '0;
            state <= IDLE;
          end
        end
        DRD: begin
          if (bottom + 1'b1 < rows_eff) begin
            state <= DCHK;
          end else begin
            right <= sc;
            k <= sr;
            state <= RRD;
          end
        end
        DCHK: begin
          if (rd_code == code) begin
            bottom <= bottom + 1'b1;
            state <= DRD;
          end else begin
            right <= sc;
            k <= sr;
            state <= RRD;
          end
        end
        RRD: begin
          if (right + 1'b1 < cols_eff) state <= RCHK;
          else state <= CINIT;
        end
        RCHK: begin
          if (rd_code != code) begin
            state <= CINIT;
          end else if (k == bottom) begin
            right <= right + 1'b1;
            k <= sr;
            state <= RRD;
          end else begin
            k <= k + 1'b1;
            state <= RRD;
          end
        end
        CINIT: begin
          c <= sc;
          k <= sr;
          rect_left <= sc;
          rect_top <= sr;
          rect_right <= right + 1'b1;
          rect_bottom <= bottom + 1'b1;
          rect_code <= code;
          state <= COV;
        end
        COV: begin
          if (k == bottom) begin
            k <= sr;
            if (c == right) state <= EMIT;
            else c <= c + 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end
        EMIT: begin
          result_strobe <= 1'b1;
          shape_code <= rect_code;
          state <= IDLE;
          if (rect_code == vcode) begin
            line_is_vertical <= 1'b1;
            lines_pending <= 1'b1;
            line_cursor <= rect_left + 1'b1;
            shape_kind <= tgrm_pkg::KIND_VLINE;
            left_px <= px(rect_left);
            right_px <= px(rect_left);
            top_px <= px(rect_top);
            bottom_px <= px(rect_bottom);
          end else if (rect_code == hcode) begin
            line_is_vertical <= 1'b0;
            lines_pending <= 1'b1;
            line_cursor <= rect_top + 1'b1;
            shape_kind <= tgrm_pkg::KIND_HLINE;
            left_px <= px(rect_left);
            right_px <= px(rect_right);
            top_px <= px(rect_top);
            bottom_px <= px(rect_top);
          end else begin
            shape_kind <= tgrm_pkg::KIND_RECT;
            left_px <= px(rect_left);
            right_px <= px(rect_right);
            top_px <= px(rect_top);
            bottom_px <= px(rect_bottom);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
